// ----- sv/btn_dbnc_pkg.sv -----
// constants and types shared by the button debounce block
// no dependencies

package btn_dbnc_pkg;

    localparam int NUM_KEYS  = 5;   // buttons scanned per item
    localparam int LONG_KEYS = 3;   // buttons below this index may give a long event
    localparam int LEVELS_W  = 5;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int BTN_W     = 3;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // register indexes, taken from paddr[2]
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = CFG_W'(50);
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(1000);

    typedef logic [TIME_W-1:0] time_ms_t;

endpackage

// ----- sv/button_debounce_short_long_press.sv -----
// button debounce with short and long press events, top level
// depends on btn_dbnc_pkg
//
// channel   signals                                   payload
// in        in_valid / in_ready                       levels, now_ms
// out       out_valid / out_ready                     event_present, button, long_press
// cfg       psel penable pwrite paddr pwdata prdata   debounce window @0x0, hold window @0x4
//
// one item per clock sustained while each result is taken as it appears; an accepted item
// enters the input register, which feeds the evaluation logic, which loads the result register
// per-button state is updated at the same edge the result is registered,
// so the next item sees it with no bubble
// a waiting result holds the input register; in_ready drops only when both are full
// and the result is not being taken
// reset releases all buttons and loads the register defaults

module button_debounce_short_long_press
    import btn_dbnc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [LEVELS_W-1:0] levels,
    input  logic [TIME_W-1:0]   now_ms,

    output logic                out_valid,
    input  logic                out_ready,
    output logic                event_present,
    output logic [BTN_W-1:0]    button,
    output logic                long_press,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [CFG_W-1:0]    debounce_reg;
    logic [CFG_W-1:0]    long_press_reg;

    logic                in_valid_reg;
    logic [LEVELS_W-1:0] levels_reg;
    time_ms_t            now_reg;

    logic                out_valid_reg;
    logic                event_reg;
    logic [BTN_W-1:0]    button_reg;
    logic                long_reg;

    logic [NUM_KEYS-1:0] last_level_reg;
    logic [NUM_KEYS-1:0] held_reg;
    logic [NUM_KEYS-1:0] long_sent_reg;
    time_ms_t            stable_since_reg [NUM_KEYS];
    time_ms_t            press_time_reg   [NUM_KEYS];

    logic [NUM_KEYS-1:0] last_level_next;
    logic [NUM_KEYS-1:0] held_next;
    logic [NUM_KEYS-1:0] long_sent_next;
    time_ms_t            stable_since_next [NUM_KEYS];
    time_ms_t            press_time_next   [NUM_KEYS];

    logic                event_next;
    logic [BTN_W-1:0]    button_next;
    logic                long_next;

    logic                advance;
    logic                cfg_write;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_LONG_PRESS) ? DATA_W'(long_press_reg)
                                                    : DATA_W'(debounce_reg);

    // per-button evaluation, stopping at the first button with an event
    always_comb
    begin
        logic [NUM_KEYS-1:0] lv;
        logic                lvl;
        logic                stable;
        logic                long_due;
        logic                found;
        logic                short_ev;
        logic                long_ev;

        lv          = NUM_KEYS'(levels_reg);   // buttons beyond the field read pressed
        found       = 1'b0;
        event_next  = 1'b0;
        button_next = '0;
        long_next   = 1'b0;

        for (int k = 0; k < NUM_KEYS; k++)
        begin
            last_level_next[k]   = last_level_reg[k];
            held_next[k]         = held_reg[k];
            long_sent_next[k]    = long_sent_reg[k];
            stable_since_next[k] = stable_since_reg[k];
            press_time_next[k]   = press_time_reg[k];

            lvl      = lv[k];
            short_ev = 1'b0;
            long_ev  = 1'b0;

            if (!found)
            begin
                last_level_next[k] = lvl;
                if (lvl != last_level_reg[k])
                begin
                    stable_since_next[k] = now_reg;
                end
                stable   = (now_reg - stable_since_next[k]) >= time_ms_t'(debounce_reg);
                long_due = (k < LONG_KEYS)
                        && ((now_reg - press_time_reg[k]) >= time_ms_t'(long_press_reg));

                if (stable)
                begin
                    if (!lvl && !held_reg[k])
                    begin
                        held_next[k]       = 1'b1;
                        press_time_next[k] = now_reg;
                        long_sent_next[k]  = 1'b0;
                    end
                    else if (!lvl && !long_sent_reg[k])
                    begin
                        if (long_due)
                        begin
                            long_sent_next[k] = 1'b1;
                            long_ev           = 1'b1;
                        end
                    end
                    else if (lvl && held_reg[k])
                    begin
                        held_next[k] = 1'b0;
                        short_ev     = !long_sent_reg[k];
                    end
                end

                if (short_ev || long_ev)
                begin
                    found       = 1'b1;
                    event_next  = 1'b1;
                    button_next = BTN_W'(k);
                    long_next   = long_ev;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_level_reg <= '1;
            held_reg       <= '0;
            long_sent_reg  <= '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                stable_since_reg[k] <= '0;
                press_time_reg[k]   <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[2])
                    REG_DEBOUNCE:   debounce_reg   <= pwdata[CFG_W-1:0];
                    REG_LONG_PRESS: long_press_reg <= pwdata[CFG_W-1:0];
                    default:        ;
                endcase
            end

            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                last_level_reg <= last_level_next;
                held_reg       <= held_next;
                long_sent_reg  <= long_sent_next;
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    stable_since_reg[k] <= stable_since_next[k];
                    press_time_reg[k]   <= press_time_next[k];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            levels_reg <= levels;
            now_reg    <= now_ms;
        end
        if (advance)
        begin
            event_reg  <= event_next;
            button_reg <= button_next;
            long_reg   <= long_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_present = event_reg;
    assign button        = button_reg;
    assign long_press    = long_reg;

    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !event_present |-> button == '0 && !long_press)
        else $error("no-event item carries a button or long flag");

    a_long_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_present && long_press |-> button < BTN_W'(LONG_KEYS))
        else $error("long event from a button that cannot give one");

    a_long_sent_range: assert property (@(posedge clk) disable iff (!rst_n)
        (long_sent_reg >> LONG_KEYS) == '0)
        else $error("long flag set on a short-only button");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(now_reg))
        else $error("item in the input register lost while stalled");

endmodule

// ----- tb/button_debounce_short_long_press_test.sv -----
// self-checking test of button_debounce_short_long_press: directed button sequences,
// then random press, hold and bounce traffic under several debounce and hold windows
// depends on btn_dbnc_pkg and the block itself

module button_debounce_short_long_press_test
    import btn_dbnc_pkg::*;
();

    typedef struct packed {
        logic             present;
        logic [BTN_W-1:0] key;
        logic             is_long;
    } key_event_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [LEVELS_W-1:0] levels;
    logic [TIME_W-1:0]   now_ms;
    logic                out_valid;
    logic                out_ready;
    logic                event_present;
    logic [BTN_W-1:0]    button;
    logic                long_press;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // shadow of the block's windows and per-button state
    logic [CFG_W-1:0] dbnc_window;
    logic [CFG_W-1:0] hold_window;
    logic             key_level     [NUM_KEYS];
    time_ms_t         key_stable_at [NUM_KEYS];
    logic             key_held      [NUM_KEYS];
    time_ms_t         key_pressed_at[NUM_KEYS];
    logic             key_long_done [NUM_KEYS];

    key_event_t expected_events[$];
    int         fail_count = 0;
    logic       gaps_on;
    logic       stalls_on;

    button_debounce_short_long_press u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .levels        (levels),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_present (event_present),
        .button        (button),
        .long_press    (long_press),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // scans the buttons in index order and stops at the first event
    function automatic key_event_t predict_key_event(input logic [LEVELS_W-1:0] lv,
                                                     input time_ms_t t);
        key_event_t ev;
        logic       lvl;
        logic       found;
        ev    = '0;
        found = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (!found)
            begin
                lvl = (k < LEVELS_W) ? lv[k] : 1'b0;
                if (lvl != key_level[k])
                    key_stable_at[k] = t;
                key_level[k] = lvl;
                if (time_ms_t'(t - key_stable_at[k]) >= time_ms_t'(dbnc_window))
                begin
                    if (!lvl && !key_held[k])
                    begin
                        key_held[k]       = 1'b1;
                        key_pressed_at[k] = t;
                        key_long_done[k]  = 1'b0;
                    end
                    else if (!lvl && key_held[k] && !key_long_done[k])
                    begin
                        if (k < LONG_KEYS &&
                            time_ms_t'(t - key_pressed_at[k]) >= time_ms_t'(hold_window))
                        begin
                            key_long_done[k] = 1'b1;
                            ev.present = 1'b1;
                            ev.key     = BTN_W'(k);
                            ev.is_long = 1'b1;
                            found      = 1'b1;
                        end
                    end
                    else if (lvl && key_held[k])
                    begin
                        key_held[k] = 1'b0;
                        if (!key_long_done[k])
                        begin
                            ev.present = 1'b1;
                            ev.key     = BTN_W'(k);
                            ev.is_long = 1'b0;
                            found      = 1'b1;
                        end
                    end
                end
            end
        end
        return ev;
    endfunction

    // valid stays high after acceptance until the next call or a drain lowers it
    task automatic send_sample(input logic [LEVELS_W-1:0] lv, input time_ms_t t);
        int gap;
        gap = gaps_on ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        levels   <= lv;
        now_ms   <= t;
        do @(posedge clk); while (!in_ready);
        expected_events.push_back(predict_key_event(lv, t));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
        // two-stage pipe, allow a little slack
        repeat (4) @(posedge clk);
    endtask

    // write, then read the register back
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= {16'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        unique case (idx)
            REG_DEBOUNCE:   dbnc_window = val;
            REG_LONG_PRESS: hold_window = val;
            default: ;
        endcase
        @(posedge clk);
        if (prdata !== DATA_W'(val))
        begin
            $error("prdata: expected %0d, got %0d", val, prdata);
            fail_count++;
        end
    endtask

    task automatic set_windows(input logic [CFG_W-1:0] dbnc, input logic [CFG_W-1:0] hold);
        drain();
        write_reg(REG_DEBOUNCE, dbnc);
        write_reg(REG_LONG_PRESS, hold);
    endtask

    // held buttons with contact bounce, occasional time jumps and junk samples
    task automatic run_traffic(input int n_items, input time_ms_t t_start);
        logic [LEVELS_W-1:0] target;
        logic [LEVELS_W-1:0] lv;
        time_ms_t            t;
        int unsigned         step_max;
        int                  pick;
        target   = '1;
        t        = t_start;
        step_max = (int'(dbnc_window) + int'(hold_window)) / 6 + 2;
        repeat (n_items)
        begin
            for (int k = 0; k < LEVELS_W; k++)
                if ($urandom_range(0, 11) == 0)
                    target[k] = ~target[k];
            lv = target;
            for (int k = 0; k < LEVELS_W; k++)
                if ($urandom_range(0, 15) == 0)
                    lv[k] = ~lv[k];
            pick = $urandom_range(0, 19);
            if (pick == 0)
                t = $urandom;
            else if (pick == 1)
                lv = LEVELS_W'($urandom);
            t = t + $urandom_range(0, step_max);
            send_sample(lv, t);
        end
    endtask

    task automatic test_default_press();
        send_sample(5'b11111, 32'd0);
        send_sample(5'b11110, 32'd100);
        send_sample(5'b11110, 32'd150);
        send_sample(5'b11110, 32'd1150);
        send_sample(5'b11111, 32'd1200);
        send_sample(5'b11111, 32'd1250);
    endtask

    // all pressed together: at most one event per item, lowest index first
    task automatic test_key_priority();
        send_sample(5'b00000, 32'd6000);
        send_sample(5'b00000, 32'd6050);
        send_sample(5'b00000, 32'd7050);
        send_sample(5'b00000, 32'd7051);
        send_sample(5'b00000, 32'd7052);
        send_sample(5'b11111, 32'd7100);
        send_sample(5'b11111, 32'd7150);
        send_sample(5'b11111, 32'd7151);
    endtask

    // long event comes on the item after the press, never on the press itself
    task automatic test_zero_windows();
        set_windows('0, '0);
        send_sample(5'b11110, 32'd10);
        send_sample(5'b11110, 32'd10);
        send_sample(5'b11111, 32'd11);
        send_sample(5'b10111, 32'd12);
        send_sample(5'b11111, 32'd12);
    endtask

    task automatic test_max_windows();
        set_windows('1, '1);
        send_sample(5'b11101, 32'hFFFF_0000);
        send_sample(5'b11101, 32'hFFFF_FFFF);
        send_sample(5'b11101, 32'h0000_FFFE);
        send_sample(5'b11111, 32'h0001_0000);
    endtask

    task automatic test_random_traffic();
        set_windows(16'd5, 16'd40);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_traffic(80, $urandom);
        drain();
        run_traffic(70, $urandom);

        set_windows('0, '0);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_traffic(100, $urandom);

        set_windows('1, '1);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_traffic(80, $urandom);

        gaps_on   = 1'b1;
        stalls_on = 1'b0;
        repeat (3)
        begin
            set_windows(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 300)));
            run_traffic(50, 32'hFFFF_FFFF - $urandom_range(0, 2000));
        end

        repeat (3)
        begin
            set_windows(CFG_W'($urandom), CFG_W'($urandom));
            gaps_on   = 1'($urandom);
            stalls_on = 1'($urandom);
            run_traffic(40, $urandom);
        end
    endtask

    // receiver: random stall before each result
    initial
    begin
        int stall;
        out_ready = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = stalls_on ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                out_ready <= 1'b1;
            end
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        key_event_t exp_ev;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected item: event_present %0d button %0d long_press %0d",
                       event_present, button, long_press);
                fail_count++;
            end
            else
            begin
                exp_ev = expected_events.pop_front();
                if (event_present !== exp_ev.present)
                begin
                    $error("event_present: expected %0d, got %0d", exp_ev.present, event_present);
                    fail_count++;
                end
                if (button !== exp_ev.key)
                begin
                    $error("button: expected %0d, got %0d", exp_ev.key, button);
                    fail_count++;
                end
                if (long_press !== exp_ev.is_long)
                begin
                    $error("long_press: expected %0d, got %0d", exp_ev.is_long, long_press);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        in_valid  = 1'b0;
        levels    = '1;
        now_ms    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        rst_n     = 1'b0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        dbnc_window = DEBOUNCE_RST;
        hold_window = LONG_PRESS_RST;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_level[k]      = 1'b1;
            key_stable_at[k]  = '0;
            key_held[k]       = 1'b0;
            key_pressed_at[k] = '0;
            key_long_done[k]  = 1'b0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_press();
        test_key_priority();
        test_zero_windows();
        test_max_windows();
        test_random_traffic();

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("button_debounce_short_long_press regression: pass");
        else
            $display("button_debounce_short_long_press regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("button_debounce_short_long_press regression: fail");
        $finish;
    end

endmodule
